// ===== rtl/lome_pkg.sv =====
// ----------------------------------------------------------------------------
// lome_pkg
// Shared constants and types of the limit order matching engine.
// ----------------------------------------------------------------------------
package lome_pkg;

    localparam int BOOK_DEPTH  = 32;
    localparam int IDX_BITS    = $clog2(BOOK_DEPTH);
    localparam int PRICE_BITS  = 16;
    localparam int QTY_BITS    = 16;
    localparam int ID_BITS     = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    localparam logic SIDE_BUY  = 1'b0;
    localparam logic SIDE_SELL = 1'b1;

    localparam logic KIND_FILL    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic                  side;
        logic [PRICE_BITS-1:0] price;
        logic [QTY_BITS-1:0]   qty;
        logic [ID_BITS-1:0]    id;
    } t_order;

    typedef struct packed {
        logic [ID_BITS-1:0]    id;
        logic [PRICE_BITS-1:0] price;
        logic [QTY_BITS-1:0]   qty;
    } t_entry;

    typedef struct packed {
        logic                  kind;
        logic [ID_BITS-1:0]    taker_id;
        logic [ID_BITS-1:0]    maker_id;
        logic [PRICE_BITS-1:0] fill_price;
        logic [QTY_BITS-1:0]   fill_quantity;
        logic [QTY_BITS-1:0]   rested_quantity;
        logic                  book_full;
        logic                  last;
    } t_result;

endpackage

// ===== rtl/limit_order_matching_engine.sv =====
// Each fill takes a pass over the 32 book slots at one registered read per
// cycle, then an evaluate and a fill; each order adds a pop and a summary.
// A remainder that rests adds one more scan, evaluate and rest; a zero
// quantity goes straight to rest. The engine pops the next order only from
// idle, after the summary; a 4-deep order queue lets input run ahead.
// Synchronous active-low reset empties both books and zeroes the id counter.
// ----------------------------------------------------------------------------
// limit_order_matching_engine
// Price-time priority matching of limit orders against a bid and ask book.
// ----------------------------------------------------------------------------
module limit_order_matching_engine (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_side,
    input  logic [lome_pkg::PRICE_BITS-1:0] i_limit_price,
    input  logic [lome_pkg::QTY_BITS-1:0]   i_order_quantity,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_kind,
    output logic [lome_pkg::ID_BITS-1:0]    o_taker_id,
    output logic [lome_pkg::ID_BITS-1:0]    o_maker_id,
    output logic [lome_pkg::PRICE_BITS-1:0] o_fill_price,
    output logic [lome_pkg::QTY_BITS-1:0]   o_fill_quantity,
    output logic [lome_pkg::QTY_BITS-1:0]   o_rested_quantity,
    output logic                            o_book_full,
    output logic                            o_last
);
    import lome_pkg::*;

    logic    q_valid, q_pop;
    t_order  q_order;
    t_result result;

    lome_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_side           (i_side),
        .i_limit_price    (i_limit_price),
        .i_order_quantity (i_order_quantity),
        .o_q_valid        (q_valid),
        .o_q_order        (q_order),
        .i_q_pop          (q_pop)
    );

    lome_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_order   (q_order),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .o_result    (result),
        .i_out_stall (i_out_stall)
    );

    assign o_kind            = result.kind;
    assign o_taker_id        = result.taker_id;
    assign o_maker_id        = result.maker_id;
    assign o_fill_price      = result.fill_price;
    assign o_fill_quantity   = result.fill_quantity;
    assign o_rested_quantity = result.rested_quantity;
    assign o_book_full       = result.book_full;
    assign o_last            = result.last;

endmodule

// ===== rtl/lome_front.sv =====
// ----------------------------------------------------------------------------
// lome_front
// Accepts orders, stamps the sequential id and queues them for the engine.
// ----------------------------------------------------------------------------
module lome_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_side,
    input  logic [lome_pkg::PRICE_BITS-1:0] i_limit_price,
    input  logic [lome_pkg::QTY_BITS-1:0]   i_order_quantity,
    output logic                            o_q_valid,
    output lome_pkg::t_order                o_q_order,
    input  logic                            i_q_pop
);
    import lome_pkg::*;

    t_order                r_queue [QUEUE_DEPTH];
    logic [QPTR_BITS:0]    r_wr_ptr, r_rd_ptr;
    logic [ID_BITS-1:0]    r_next_id;
    logic                  full, empty, push;

    assign empty = (r_wr_ptr == r_rd_ptr);
    assign full  = (r_wr_ptr[QPTR_BITS-1:0] == r_rd_ptr[QPTR_BITS-1:0]) &&
                   (r_wr_ptr[QPTR_BITS] != r_rd_ptr[QPTR_BITS]);
    assign push  = i_in_valid && !full;

    assign o_in_stall = full;
    assign o_q_valid  = !empty;
    assign o_q_order  = r_queue[r_rd_ptr[QPTR_BITS-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr  <= '0;
            r_rd_ptr  <= '0;
            r_next_id <= '0;
        end else begin
            if (push) begin
                r_wr_ptr  <= r_wr_ptr + 1'b1;
                r_next_id <= r_next_id + 1'b1;
            end
            if (i_q_pop && !empty) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr[QPTR_BITS-1:0]] <= '{side: i_side, price: i_limit_price,
                                                 qty: i_order_quantity, id: r_next_id};
        end
    end

endmodule

// ===== rtl/lome_back.sv =====
// ----------------------------------------------------------------------------
// lome_back
// Matching sequencer: scans the opposite book for the best entry and fills,
// repeating while it crosses, then rests any remainder and reports the summary.
// ----------------------------------------------------------------------------
module lome_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  lome_pkg::t_order   i_q_order,
    output logic               o_q_pop,
    output logic               o_out_valid,
    output lome_pkg::t_result  o_result,
    input  logic               i_out_stall
);
    import lome_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SCAN = 6'b000010,
        S_EVAL = 6'b000100,
        S_FILL = 6'b001000,
        S_REST = 6'b010000,
        S_SUM  = 6'b100000
    } t_state;

    t_entry                r_bid_mem [BOOK_DEPTH];
    t_entry                r_ask_mem [BOOK_DEPTH];
    logic [BOOK_DEPTH-1:0] r_bid_valid, r_ask_valid;

    t_state                r_state;
    t_order                r_ord;
    logic [IDX_BITS:0]     r_cnt;
    logic                  r_pend;
    logic [IDX_BITS-1:0]   r_pend_idx;
    t_entry                r_rd_bid, r_rd_ask;
    logic                  r_have;
    logic [IDX_BITS-1:0]   r_best_idx;
    t_entry                r_best;
    logic                  r_full;
    logic [QTY_BITS-1:0]   r_rested;
    logic                  r_out_valid;
    t_result               r_out;

    logic                  out_free, scan_done, issue, emit;
    logic                  sell;
    t_entry                rd;
    logic                  rd_valid, better, crosses;
    logic [QTY_BITS-1:0]   trade, maker_left;
    logic [BOOK_DEPTH-1:0] own_valid;
    logic                  free_found;
    logic [IDX_BITS-1:0]   free_idx;

    assign out_free  = !r_out_valid || !i_out_stall;
    assign emit      = ((r_state == S_FILL) || (r_state == S_SUM)) && out_free;
    assign sell      = (r_ord.side == SIDE_SELL);
    assign issue     = (r_state == S_SCAN) && (r_cnt != (IDX_BITS+1)'(BOOK_DEPTH));
    assign scan_done = (r_cnt == (IDX_BITS+1)'(BOOK_DEPTH)) && !r_pend;

    // a sell scans the bids for the highest price, a buy the asks for the lowest
    assign rd       = sell ? r_rd_bid : r_rd_ask;
    assign rd_valid = sell ? r_bid_valid[r_pend_idx] : r_ask_valid[r_pend_idx];

    always_comb begin
        if (!r_have) begin
            better = 1'b1;
        end else if (rd.price != r_best.price) begin
            better = sell ? (rd.price > r_best.price) : (rd.price < r_best.price);
        end else begin
            better = (rd.id < r_best.id);
        end
    end

    assign crosses    = r_have && (sell ? (r_ord.price <= r_best.price)
                                        : (r_ord.price >= r_best.price));
    assign trade      = (r_ord.qty < r_best.qty) ? r_ord.qty : r_best.qty;
    assign maker_left = r_best.qty - trade;

    assign own_valid = sell ? r_ask_valid : r_bid_valid;
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = BOOK_DEPTH - 1; i >= 0; i--) begin
            if (!own_valid[i]) begin
                free_found = 1'b1;
                free_idx   = IDX_BITS'(i);
            end
        end
    end

    assign o_q_pop     = (r_state == S_IDLE) && i_q_valid;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    // book memories: one read and one write port each, registered read
    always_ff @(posedge i_clk) begin
        r_rd_bid <= r_bid_mem[r_cnt[IDX_BITS-1:0]];
        r_rd_ask <= r_ask_mem[r_cnt[IDX_BITS-1:0]];
        if (r_state == S_FILL && out_free) begin
            if (sell) begin
                r_bid_mem[r_best_idx] <= '{id: r_best.id, price: r_best.price,
                                           qty: maker_left};
            end else begin
                r_ask_mem[r_best_idx] <= '{id: r_best.id, price: r_best.price,
                                           qty: maker_left};
            end
        end
        if (r_state == S_REST && r_ord.qty != '0 && free_found) begin
            if (sell) begin
                r_ask_mem[free_idx] <= '{id: r_ord.id, price: r_ord.price, qty: r_ord.qty};
            end else begin
                r_bid_mem[free_idx] <= '{id: r_ord.id, price: r_ord.price, qty: r_ord.qty};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bid_valid <= '0;
            r_ask_valid <= '0;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
            r_cnt       <= '0;
            r_have      <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && !emit) begin
                r_out_valid <= 1'b0;
            end
            r_pend     <= issue;
            r_pend_idx <= r_cnt[IDX_BITS-1:0];
            if (issue) begin
                r_cnt <= r_cnt + 1'b1;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_ord   <= i_q_order;
                        r_cnt   <= '0;
                        r_have  <= 1'b0;
                        r_state <= (i_q_order.qty == '0) ? S_REST : S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_pend && rd_valid && better) begin
                        r_have     <= 1'b1;
                        r_best     <= rd;
                        r_best_idx <= r_pend_idx;
                    end
                    if (scan_done) begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    r_state <= crosses ? S_FILL : S_REST;
                end
                S_FILL: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out       <= '{kind: KIND_FILL, taker_id: r_ord.id,
                                         maker_id: r_best.id, fill_price: r_best.price,
                                         fill_quantity: trade, rested_quantity: '0,
                                         book_full: 1'b0, last: 1'b0};
                        if (maker_left == '0) begin
                            if (sell) begin
                                r_bid_valid[r_best_idx] <= 1'b0;
                            end else begin
                                r_ask_valid[r_best_idx] <= 1'b0;
                            end
                        end
                        r_ord.qty <= r_ord.qty - trade;
                        r_cnt     <= '0;
                        r_have    <= 1'b0;
                        if (r_ord.qty == trade) begin
                            r_full   <= 1'b0;
                            r_rested <= '0;
                            r_state  <= S_SUM;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_REST: begin
                    r_full   <= (r_ord.qty != '0) && !free_found;
                    r_rested <= ((r_ord.qty != '0) && free_found) ? r_ord.qty : '0;
                    if (r_ord.qty != '0 && free_found) begin
                        if (sell) begin
                            r_ask_valid[free_idx] <= 1'b1;
                        end else begin
                            r_bid_valid[free_idx] <= 1'b1;
                        end
                    end
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out       <= '{kind: KIND_SUMMARY, taker_id: r_ord.id,
                                         maker_id: '0, fill_price: '0,
                                         fill_quantity: '0, rested_quantity: r_rested,
                                         book_full: r_full, last: 1'b1};
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
